// File: hdl/nt_pkg.sv
// nt_pkg: shared types, codes and default sizes for the name table with aging
// no dependencies; used by every module of the block
package nt_pkg;

    // default sizes handed down from the top level
    localparam int TABLE_SLOTS_DEF = 32;
    localparam int FIRST_SLOT_DEF  = 2;
    localparam int NAME_BYTES_DEF  = 8;

    // fixed field widths of the ports
    localparam int NAME_W_MAX = 64;
    localparam int SLOT_W     = 5;
    localparam int ADDR_W     = 5;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 6;
    localparam int LIFE_W     = 8;

    // configuration port
    localparam int                CFG_ADDR_W     = 3;
    localparam int                CFG_DATA_W     = 32;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd3;
    localparam logic              REG_LIFETIME   = 1'b0;

    // commands
    typedef enum logic [1:0] {
        CMD_REGISTER  = 2'd0,
        CMD_RESOLVE   = 2'd1,
        CMD_KEEPALIVE = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISS     = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_MISMATCH = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // request item
    typedef struct packed {
        logic [1:0]            command;
        logic [NAME_W_MAX-1:0] name;
        logic [SLOT_W-1:0]     slot;
    } req_t;

    // result item
    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live_count;
    } rsp_t;

    // ring control from the sequencer to the cells
    typedef struct packed {
        logic shift;
        logic write;
    } ring_ctrl_t;

endpackage

// File: hdl/nt_cell.sv
// nt_cell: one slot of the ring, holding a name and its liveness counter
// depends on nt_pkg
module nt_cell #(
    parameter int NAME_W = nt_pkg::NAME_BYTES_DEF * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nt_pkg::ring_ctrl_t        ring,
    input  logic                      wr_sel,
    input  logic [NAME_W-1:0]         shift_name,
    input  logic [nt_pkg::LIFE_W-1:0] shift_life,
    input  logic [NAME_W-1:0]         wr_name,
    input  logic [nt_pkg::LIFE_W-1:0] wr_life,
    output logic [NAME_W-1:0]         name,
    output logic [nt_pkg::LIFE_W-1:0] life
);

    logic [NAME_W-1:0]         name_reg;
    logic [NAME_W-1:0]         name_next;
    logic [nt_pkg::LIFE_W-1:0] life_reg;
    logic [nt_pkg::LIFE_W-1:0] life_next;

    // take the neighbour's entry while rotating, or a new entry when selected
    always_comb
    begin
        name_next = name_reg;
        life_next = life_reg;
        if (ring.shift)
        begin
            name_next = shift_name;
            life_next = shift_life;
        end
        else if (ring.write && wr_sel)
        begin
            name_next = wr_name;
            life_next = wr_life;
        end
    end

    // entry storage, cleared to empty at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg <= '0;
            life_reg <= '0;
        end
        else
        begin
            name_reg <= name_next;
            life_reg <= life_next;
        end
    end

    assign name = name_reg;
    assign life = life_reg;

endmodule

// File: hdl/nt_ctrl.sv
// nt_ctrl: sequencer that rotates the ring once per item and inspects the head cell
// depends on nt_pkg
module nt_ctrl #(
    parameter int TABLE_SLOTS = nt_pkg::TABLE_SLOTS_DEF,
    parameter int FIRST_SLOT  = nt_pkg::FIRST_SLOT_DEF,
    parameter int NAME_BYTES  = nt_pkg::NAME_BYTES_DEF,
    localparam int NAME_W     = NAME_BYTES * 8,
    localparam int IDX_W      = $clog2(TABLE_SLOTS),
    localparam int CNT_W      = $clog2(TABLE_SLOTS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  nt_pkg::req_t              req,
    input  logic [nt_pkg::LIFE_W-1:0] lifetime,
    input  logic [NAME_W-1:0]         head_name,
    input  logic [nt_pkg::LIFE_W-1:0] head_life,
    output logic [NAME_W-1:0]         head_name_next,
    output logic [nt_pkg::LIFE_W-1:0] head_life_next,
    output nt_pkg::ring_ctrl_t        ring,
    output logic [IDX_W-1:0]          wr_idx,
    output logic [NAME_W-1:0]         wr_name,
    output logic                      busy,
    output logic                      done,
    output nt_pkg::rsp_t              rsp
);

    nt_pkg::state_t            state_reg;
    nt_pkg::state_t            state_next;
    logic [IDX_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          cnt_next;
    logic [1:0]                cmd_reg;
    logic [1:0]                cmd_next;
    logic [NAME_W-1:0]         name_reg;
    logic [NAME_W-1:0]         name_next;
    logic [nt_pkg::SLOT_W-1:0] slot_reg;
    logic [nt_pkg::SLOT_W-1:0] slot_next;
    logic                      found_reg;
    logic                      found_next;
    logic [IDX_W-1:0]          found_idx_reg;
    logic [IDX_W-1:0]          found_idx_next;
    logic                      free_reg;
    logic                      free_next;
    logic [IDX_W-1:0]          free_idx_reg;
    logic [IDX_W-1:0]          free_idx_next;
    logic [CNT_W-1:0]          occ_reg;
    logic [CNT_W-1:0]          occ_next;
    logic                      done_reg;
    logic                      done_next;
    nt_pkg::rsp_t              rsp_reg;
    nt_pkg::rsp_t              rsp_next;

    logic                      last_slot;
    logic                      in_range;
    logic                      name_nz;
    logic                      head_occ;
    logic                      hit;
    logic                      reg_ok;
    logic [IDX_W-1:0]          addr_sel;
    logic [31:0]               addr32;
    logic [31:0]               occ32;
    logic [1:0]                status_sel;

    // head cell inspection
    assign last_slot = (cnt_reg == IDX_W'(TABLE_SLOTS - 1));
    assign in_range  = (32'(cnt_reg) >= 32'(FIRST_SLOT));
    assign name_nz   = |name_reg;
    assign head_occ  = |head_name;
    assign hit       = in_range && name_nz && (head_name == name_reg);
    assign reg_ok    = (cmd_reg == nt_pkg::CMD_REGISTER) && name_nz && !found_reg && free_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nt_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = nt_pkg::ST_SCAN;
            end
            nt_pkg::ST_SCAN:
            begin
                if (last_slot)
                    state_next = nt_pkg::ST_DONE;
            end
            nt_pkg::ST_DONE:
            begin
                state_next = nt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nt_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy       = 1'b1;
        ring.shift = 1'b0;
        ring.write = 1'b0;
        case (state_reg)
            nt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            nt_pkg::ST_SCAN:
            begin
                ring.shift = 1'b1;
            end
            nt_pkg::ST_DONE:
            begin
                ring.write = reg_ok;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // per-slot scan work and end-of-pass result
    always_comb
    begin
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        name_next      = name_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        occ_next       = occ_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        head_name_next = head_name;
        head_life_next = head_life;
        addr_sel       = '0;
        status_sel     = nt_pkg::STATUS_OK;
        case (state_reg)
            nt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    cmd_next   = req.command;
                    name_next  = req.name[NAME_W-1:0];
                    slot_next  = req.slot;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                end
            end
            nt_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                case (cmd_reg)
                    nt_pkg::CMD_REGISTER, nt_pkg::CMD_RESOLVE:
                    begin
                        if (hit && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = cnt_reg;
                        end
                        if ((cmd_reg == nt_pkg::CMD_REGISTER) && in_range && !head_occ
                            && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = cnt_reg;
                        end
                    end
                    nt_pkg::CMD_KEEPALIVE:
                    begin
                        // claimed slot must hold this very name
                        if (hit && (32'(cnt_reg) == 32'(slot_reg)))
                        begin
                            found_next     = 1'b1;
                            found_idx_next = cnt_reg;
                            head_life_next = lifetime;
                        end
                    end
                    default:
                    begin
                        // aging tick: occupied slots only
                        if (in_range && head_occ)
                        begin
                            if (head_life == '0)
                            begin
                                head_name_next = '0;
                                if (occ_reg != '0)
                                    occ_next = occ_reg - CNT_W'(1);
                            end
                            else
                            begin
                                head_life_next = head_life - nt_pkg::LIFE_W'(1);
                            end
                        end
                    end
                endcase
            end
            nt_pkg::ST_DONE:
            begin
                case (cmd_reg)
                    nt_pkg::CMD_REGISTER:
                    begin
                        if (!name_nz || found_reg)
                            status_sel = nt_pkg::STATUS_MISS;
                        else if (!free_reg)
                            status_sel = nt_pkg::STATUS_FULL;
                        else
                        begin
                            addr_sel = free_idx_reg;
                            occ_next = occ_reg + CNT_W'(1);
                        end
                    end
                    nt_pkg::CMD_RESOLVE:
                    begin
                        if (found_reg)
                            addr_sel = found_idx_reg;
                        else
                            status_sel = nt_pkg::STATUS_MISS;
                    end
                    nt_pkg::CMD_KEEPALIVE:
                    begin
                        if (found_reg)
                            addr_sel = found_idx_reg;
                        else
                            status_sel = nt_pkg::STATUS_MISMATCH;
                    end
                    default:
                    begin
                        status_sel = nt_pkg::STATUS_OK;
                    end
                endcase
                done_next           = 1'b1;
                rsp_next.address    = addr32[nt_pkg::ADDR_W-1:0];
                rsp_next.status     = status_sel;
                rsp_next.live_count = occ32[nt_pkg::LIVE_W-1:0];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign addr32 = 32'(addr_sel);
    assign occ32  = 32'(occ_next);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nt_pkg::ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // item and scan payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        cmd_reg       <= cmd_next;
        name_reg      <= name_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        rsp_reg       <= rsp_next;
    end

    assign wr_idx  = free_idx_reg;
    assign wr_name = name_reg;
    assign done    = done_reg;
    assign rsp     = rsp_reg;

endmodule

// File: hdl/name_table_with_aging.sv
// name_table_with_aging: top level, ring of slot cells, sequencer and config register
// depends on nt_pkg, nt_cell, nt_ctrl
//
// Each command keeps busy high while the slot entries, held in a ring of cells,
// rotate once past the head cell, one slot per cycle, and then while the done
// state writes a new entry and forms the result. start is taken when busy is
// low, so a new item cannot enter before the last one is through. The single
// result of each item appears on rsp, marked by done for a single cycle, in the
// cycle in which busy falls; it cannot be held off and must be captured then.
// entry_lifetime sits at byte address 0 of the APB port and should be written
// only while busy is low.
module name_table_with_aging #(
    parameter int TABLE_SLOTS = nt_pkg::TABLE_SLOTS_DEF,
    parameter int FIRST_SLOT  = nt_pkg::FIRST_SLOT_DEF,
    parameter int NAME_BYTES  = nt_pkg::NAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  nt_pkg::req_t                  req,
    output logic                          busy,
    output logic                          done,
    output nt_pkg::rsp_t                  rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [nt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int NAME_W = NAME_BYTES * 8;
    localparam int IDX_W  = $clog2(TABLE_SLOTS);

    logic [nt_pkg::LIFE_W-1:0] lifetime_reg;
    logic [nt_pkg::LIFE_W-1:0] lifetime_next;
    logic                      cfg_hit;

    nt_pkg::ring_ctrl_t        ring;
    logic [IDX_W-1:0]          wr_idx;
    logic [NAME_W-1:0]         wr_name;
    logic [NAME_W-1:0]         head_name_next;
    logic [nt_pkg::LIFE_W-1:0] head_life_next;
    logic [NAME_W-1:0]         cell_name [TABLE_SLOTS];
    logic [nt_pkg::LIFE_W-1:0] cell_life [TABLE_SLOTS];

    // configuration register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == nt_pkg::REG_LIFETIME);

    always_comb
    begin
        lifetime_next = lifetime_reg;
        if (psel && penable && pwrite && cfg_hit)
            lifetime_next = pwdata[nt_pkg::LIFE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lifetime_reg <= nt_pkg::LIFETIME_RESET;
        else
            lifetime_reg <= lifetime_next;
    end

    assign prdata = cfg_hit ? nt_pkg::CFG_DATA_W'(lifetime_reg) : '0;

    // sequencer
    nt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .FIRST_SLOT  (FIRST_SLOT),
        .NAME_BYTES  (NAME_BYTES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req            (req),
        .lifetime       (lifetime_reg),
        .head_name      (cell_name[0]),
        .head_life      (cell_life[0]),
        .head_name_next (head_name_next),
        .head_life_next (head_life_next),
        .ring           (ring),
        .wr_idx         (wr_idx),
        .wr_name        (wr_name),
        .busy           (busy),
        .done           (done),
        .rsp            (rsp)
    );

    // ring of slot cells, the head entry returns at the tail after inspection
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        logic [NAME_W-1:0]         nb_name;
        logic [nt_pkg::LIFE_W-1:0] nb_life;

        if (i == TABLE_SLOTS - 1)
        begin : g_tail
            assign nb_name = head_name_next;
            assign nb_life = head_life_next;
        end
        else
        begin : g_body
            assign nb_name = cell_name[i+1];
            assign nb_life = cell_life[i+1];
        end

        nt_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ring       (ring),
            .wr_sel     (wr_idx == IDX_W'(i)),
            .shift_name (nb_name),
            .shift_life (nb_life),
            .wr_name    (wr_name),
            .wr_life    (lifetime_reg),
            .name       (cell_name[i]),
            .life       (cell_life[i])
        );
    end

endmodule

// File: hdl/nt_checker.sv
// nt_props: port-level assertions for the name table, bound to the top level
// depends on nt_pkg and name_table_with_aging
module nt_props #(
    parameter int TABLE_SLOTS = nt_pkg::TABLE_SLOTS_DEF,
    parameter int FIRST_SLOT  = nt_pkg::FIRST_SLOT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input nt_pkg::rsp_t rsp
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an accepted item");

    // a result only once the scan is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // one result per item, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a failed command reports no slot
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == nt_pkg::STATUS_MISS || rsp.status == nt_pkg::STATUS_FULL
                 || rsp.status == nt_pkg::STATUS_MISMATCH) |-> rsp.address == '0)
        else $error("failed command returned a slot");

    // occupancy never exceeds the usable slots
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> 32'(rsp.live_count) <= 32'(TABLE_SLOTS - FIRST_SLOT))
        else $error("live count above usable slots");

endmodule

bind name_table_with_aging nt_props #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .FIRST_SLOT  (FIRST_SLOT)
) u_nt_props (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// File: sim/nt_checker.sv
`timescale 1ns / 100ps
// nt_checker: watches the request, result and register ports of the name table,
// predicts every result from its own copy of the table and compares field by field
// depends on nt_pkg
module nt_checker #(
    parameter int TABLE_SLOTS = nt_pkg::TABLE_SLOTS_DEF,
    parameter int FIRST_SLOT  = nt_pkg::FIRST_SLOT_DEF,
    parameter int NAME_BYTES  = nt_pkg::NAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  nt_pkg::req_t                  req,
    input  logic                          busy,
    input  logic                          done,
    input  nt_pkg::rsp_t                  rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nt_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic [nt_pkg::CFG_DATA_W-1:0] prdata,
    input  logic                          pready,
    output int                            pending,
    output int                            errors
);
    import nt_pkg::*;

    localparam logic [NAME_W_MAX-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {NAME_W_MAX{1'b1}} :
                                                  ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
    localparam logic [CFG_ADDR_W-1:0] LIFETIME_ADDR = CFG_ADDR_W'(4 * REG_LIFETIME);

    // shadow of the table
    logic [NAME_W_MAX-1:0] table_name [TABLE_SLOTS];
    logic [8:0]            table_life [TABLE_SLOTS];
    int                    live_total;
    logic [LIFE_W-1:0]     lifetime;

    // results owed by the block, oldest first
    rsp_t expected_q[$];
    rsp_t oldest;

    // slot holding a name, 0 when none; empty names never match
    function automatic int find_slot(logic [NAME_W_MAX-1:0] nm);
        if (nm == '0)
            return 0;
        for (int i = FIRST_SLOT; i < TABLE_SLOTS; i++)
            if (table_name[i] == nm)
                return i;
        return 0;
    endfunction

    // applies one command to the shadow table and returns the result it owes
    function automatic rsp_t apply_command(req_t r);
        logic [NAME_W_MAX-1:0] nm;
        int                    addr;
        status_t               st;
        rsp_t                  res;
        nm   = r.name & NAME_MASK;
        addr = 0;
        st   = STATUS_OK;
        case (cmd_t'(r.command))
            CMD_REGISTER:
            begin
                if (nm == '0 || find_slot(nm) != 0)
                    st = STATUS_MISS;
                else
                begin
                    st = STATUS_FULL;
                    for (int i = FIRST_SLOT; i < TABLE_SLOTS; i++)
                    begin
                        if (table_name[i] == '0)
                        begin
                            table_name[i] = nm;
                            table_life[i] = 9'(lifetime);
                            live_total++;
                            addr = i;
                            st   = STATUS_OK;
                            break;
                        end
                    end
                end
            end
            CMD_RESOLVE:
            begin
                addr = find_slot(nm);
                st   = (addr != 0) ? STATUS_OK : STATUS_MISS;
            end
            CMD_KEEPALIVE:
            begin
                if (int'(r.slot) >= FIRST_SLOT && int'(r.slot) < TABLE_SLOTS && nm != '0 &&
                    table_name[r.slot] == nm)
                begin
                    table_life[r.slot] = 9'(lifetime);
                    addr = int'(r.slot);
                end
                else
                    st = STATUS_MISMATCH;
            end
            default:
            begin
                // aging tick: free slots are skipped, expired ones are freed
                for (int i = FIRST_SLOT; i < TABLE_SLOTS; i++)
                begin
                    if (table_name[i] != '0)
                    begin
                        if (table_life[i] == '0)
                        begin
                            table_name[i] = '0;
                            if (live_total > 0)
                                live_total--;
                        end
                        else
                            table_life[i] = table_life[i] - 9'd1;
                    end
                end
            end
        endcase
        res.address    = addr[ADDR_W-1:0];
        res.status     = st;
        res.live_count = live_total[LIVE_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // observe all channels on the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                table_name[i] = '0;
                table_life[i] = '0;
            end
            live_total = 0;
            lifetime   = LIFETIME_RESET;
            errors     = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // results leave first, an item taken on the same edge queues behind
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, expected no item, got %0d/%0d/%0d",
                             $time, rsp.address, rsp.status, rsp.live_count);
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    check_field("address", 32'(oldest.address), 32'(rsp.address));
                    check_field("status", 32'(oldest.status), 32'(rsp.status));
                    check_field("live_count", 32'(oldest.live_count), 32'(rsp.live_count));
                end
            end

            // register access phase
            if (psel && penable && pready && paddr == LIFETIME_ADDR)
            begin
                if (pwrite)
                    lifetime = pwdata[LIFE_W-1:0];
                else
                    check_field("entry_lifetime read", 32'(lifetime), prdata);
            end

            // accepted command item
            if (start && !busy)
                expected_q.push_back(apply_command(req));

            pending <= expected_q.size();
        end
    end

endmodule

// File: sim/tb_name_table_with_aging.sv
`timescale 1ns / 100ps
// tb_name_table_with_aging: clock, reset, command and register stimulus, and verdict
// depends on nt_pkg, name_table_with_aging and nt_checker
module tb_name_table_with_aging;
    import nt_pkg::*;

    localparam int POOL_SIZE     = 40;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam logic [CFG_ADDR_W-1:0] LIFETIME_ADDR = CFG_ADDR_W'(4 * REG_LIFETIME);

    typedef struct {
        cmd_t command;
        int   pool_idx;
    } sent_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    req_t                  req;
    logic                  busy;
    logic                  done;
    rsp_t                  rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    errors;
    int                    cycle_count = 0;

    // names in play and the slot each was last given
    logic [NAME_W_MAX-1:0] name_pool [POOL_SIZE];
    logic [ADDR_W-1:0]     last_slot [POOL_SIZE];
    sent_t                 sent_q[$];

    name_table_with_aging uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nt_checker table_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pending (pending),
        .errors  (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // learn slots from registrations so keepalives can claim them
    always @(posedge clk)
    begin
        sent_t s;
        if (done && sent_q.size() != 0)
        begin
            s = sent_q.pop_front();
            if (s.command == CMD_REGISTER && rsp.status == STATUS_OK && s.pool_idx >= 0)
                last_slot[s.pool_idx] = rsp.address;
        end
    end

    // one command item, after an optional idle gap
    task automatic issue(cmd_t c, int idx, logic [NAME_W_MAX-1:0] nm, logic [SLOT_W-1:0] s,
                         int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{command: c, name: nm, slot: s};
        do @(posedge clk); while (busy);
        sent_q.push_back('{command: c, pool_idx: idx});
    endtask

    // hold off until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write the lifetime register, then read it back
    task automatic set_lifetime(logic [LIFE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIFETIME_ADDR;
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int pick_gap(int pct);
        int g = 0;
        while (g < 20 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    // register the whole pool in random order, overflowing the table
    task automatic fill_table(int pct);
        int order [POOL_SIZE];
        int j;
        int t;
        for (int i = 0; i < POOL_SIZE; i++)
            order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            issue(CMD_REGISTER, order[i], name_pool[order[i]], SLOT_W'($urandom), pick_gap(pct));
    endtask

    // random command, mostly on known names, keepalives mostly on the right slot
    task automatic random_item(int pct);
        int                    roll;
        int                    idx;
        cmd_t                  c;
        logic [NAME_W_MAX-1:0] nm;
        logic [SLOT_W-1:0]     s;
        roll = $urandom_range(99);
        if (roll < 35)
            c = CMD_REGISTER;
        else if (roll < 60)
            c = CMD_RESOLVE;
        else if (roll < 85)
            c = CMD_KEEPALIVE;
        else
            c = CMD_TICK;
        roll = $urandom_range(99);
        if (roll < 84)
        begin
            idx = $urandom_range(POOL_SIZE - 1);
            nm  = name_pool[idx];
        end
        else if (roll < 92)
        begin
            idx = -1;
            nm  = '0;
        end
        else
        begin
            idx = -1;
            nm  = {$urandom, $urandom};
        end
        s = SLOT_W'($urandom_range(31));
        if (c == CMD_KEEPALIVE && idx >= 0 && last_slot[idx] != '0 && $urandom_range(99) < 75)
            s = last_slot[idx];
        issue(c, idx, nm, s, pick_gap(pct));
    endtask

    initial
    begin
        int phase_life [PHASES];
        int phase_idle [PHASES];
        int n;

        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // pool of names: extremes first, then random non-empty ones
        name_pool[0] = {NAME_W_MAX{1'b1}};
        name_pool[1] = 64'h8000_0000_0000_0000;
        for (int i = 2; i < POOL_SIZE; i++)
            name_pool[i] = {$urandom, $urandom} | 64'h1;
        for (int i = 0; i < POOL_SIZE; i++)
            last_slot[i] = '0;

        phase_life    = '{255, 1, 0, 3, 255, 7, 2};
        phase_life[3] = $urandom_range(2, 254);
        phase_idle    = '{0, 49, 36, 0, 49, 36, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects, duplicates, lookups, keepalive corner slots, expiry
        issue(CMD_REGISTER, -1, '0, 5'd0, 0);
        issue(CMD_REGISTER, 0, name_pool[0], 5'd31, 0);
        issue(CMD_REGISTER, 1, name_pool[1], 5'd0, 0);
        issue(CMD_REGISTER, 2, name_pool[2], 5'd0, 0);
        issue(CMD_REGISTER, 0, name_pool[0], 5'd0, 0);
        issue(CMD_RESOLVE, 1, name_pool[1], 5'd0, 0);
        issue(CMD_RESOLVE, -1, '0, 5'd0, 0);
        issue(CMD_RESOLVE, -1, 64'h5a5a_0000_0000_00a5, 5'd0, 0);
        issue(CMD_KEEPALIVE, 0, name_pool[0], 5'd2, 0);
        issue(CMD_KEEPALIVE, 0, name_pool[0], 5'd0, 0);
        issue(CMD_KEEPALIVE, 0, name_pool[0], 5'd1, 0);
        issue(CMD_KEEPALIVE, 1, name_pool[1], 5'd31, 0);
        issue(CMD_KEEPALIVE, 1, name_pool[1], 5'd2, 0);
        issue(CMD_KEEPALIVE, -1, '0, 5'd5, 0);
        repeat (4) issue(CMD_TICK, -1, '0, 5'd0, 0);
        issue(CMD_RESOLVE, 0, name_pool[0], 5'd0, 0);

        // zero lifetime: the next tick frees the entry at once
        drain();
        set_lifetime(8'd0);
        issue(CMD_REGISTER, 3, name_pool[3], 5'd0, 0);
        issue(CMD_TICK, -1, {NAME_W_MAX{1'b1}}, 5'd31, 0);
        issue(CMD_RESOLVE, 3, name_pool[3], 5'd0, 0);

        // random phases over lifetimes and sender idling
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_lifetime(phase_life[p][LIFE_W-1:0]);
            n = 0;
            if (phase_life[p] == 255)
            begin
                fill_table(phase_idle[p]);
                n = POOL_SIZE;
            end
            while (n < PHASE_ITEMS)
            begin
                // hold off mid-phase until the table has answered everything
                if (p == 1 && n == PHASE_ITEMS / 2)
                    drain();
                random_item(phase_idle[p]);
                n++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/nt_pkg.sv
hdl/nt_cell.sv
hdl/nt_ctrl.sv
hdl/name_table_with_aging.sv
hdl/nt_checker.sv
sim/nt_checker.sv
sim/tb_name_table_with_aging.sv
